// ===== hdl/lru_kv_pkg.sv =====
// Shared constants and word types for the LRU key-value cache.
package lru_kv_pkg;

  // Number of entries held in the cache
  localparam int MAX_ENTRIES = 16;
  // Index and recency rank width
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  // Width of the fill count, which must hold MAX_ENTRIES itself
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  // Capacity register width
  localparam int CAP_W = 5;
  // Common width used to compare fill count against capacity
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Request type codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Request word
  typedef struct packed {
    logic                    req_type;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // Result word
  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } rsp_t;

endpackage

// ===== hdl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
//
//   port         dir     width  role
//   start/busy   in/out  1/1    request handshake, word taken when start && !busy
//   req          in      req_t  request word (req_type, key, value)
//   done         out     1      result strobe, one cycle per result word
//   rsp          out     rsp_t  result word (found, read_value, evicted)
//   cfg_wr_en    in      1      capacity write strobe
//   cfg_wr_data  in      5      capacity value
//
// One request per cycle; busy is never raised. A taken request is held in the
// input register, then looked up and applied against all entries in parallel
// (key match, free-slot and LRU-victim search) as its result is registered
// into rsp with done high. Synchronous reset empties the cache and sets
// capacity to 16. The receiver cannot stall the results.
module lru_key_value_cache (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  lru_kv_pkg::req_t     req,
  input  logic                 cfg_wr_en,
  input  logic [lru_kv_pkg::CAP_W-1:0] cfg_wr_data,
  output logic                 done,
  output lru_kv_pkg::rsp_t     rsp
);
  import lru_kv_pkg::*;

  // Input register
  req_t              req_q;
  logic              req_vld;

  // Capacity register
  logic [CAP_W-1:0]  capacity;

  // Entry storage
  logic [KEY_W-1:0]  keys   [MAX_ENTRIES];
  logic [VAL_W-1:0]  values [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]  rank   [MAX_ENTRIES];
  logic [CNT_W-1:0]  used;

  // Lookup results
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] victim_vec;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  victim_idx;
  logic [IDX_W-1:0]  last_rank;
  logic [CMP_W-1:0]  eff_cap;
  logic              full;

  // Update decisions
  logic              is_put;
  logic              do_promote;
  logic              do_write;
  logic              do_insert;
  logic              do_evict;
  logic [IDX_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  limit;
  logic [IDX_W-1:0]  rank_next [MAX_ENTRIES];
  rsp_t              rsp_next;

  assign busy = 1'b0;

  // Capture request word
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(MAX_ENTRIES);
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Parallel match, free-slot and victim search
  assign last_rank = IDX_W'(used - CNT_W'(1));

  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i]    = valid[i] && (keys[i] == req_q.key);
      victim_vec[i] = valid[i] && (rank[i] == last_rank);
    end
    // walk downward so the lowest index wins
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i])    hit_idx    = IDX_W'(i);
      if (!valid[i])     free_idx   = IDX_W'(i);
      if (victim_vec[i]) victim_idx = IDX_W'(i);
    end
  end

  assign hit = |hit_vec;

  // Effective capacity: zero acts as one, large values saturate
  always_comb begin
    priority if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  assign full = (CMP_W'(used) >= eff_cap) && (used != '0);

  // Choose target entry and promotion limit
  always_comb begin
    is_put     = (req_q.req_type == REQ_PUT);
    do_insert  = 1'b0;
    do_evict   = 1'b0;
    do_write   = 1'b0;
    do_promote = 1'b0;
    wr_idx     = hit_idx;
    limit      = CNT_W'(rank[hit_idx]);
    priority if (hit) begin
      do_promote = 1'b1;
      do_write   = is_put;
    end else if (is_put && full) begin
      do_evict   = 1'b1;
      do_write   = 1'b1;
      do_promote = 1'b1;
      wr_idx     = victim_idx;
      limit      = CNT_W'(last_rank);
    end else if (is_put) begin
      do_insert  = 1'b1;
      do_write   = 1'b1;
      do_promote = 1'b1;
      wr_idx     = free_idx;
      limit      = used + CNT_W'(1);
    end else begin
      do_promote = 1'b0;
    end
  end

  // Promotion: entries more recent than the limit age by one
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_next[i] = rank[i];
      if (do_promote) begin
        if (IDX_W'(i) == wr_idx) begin
          rank_next[i] = '0;
        end else if (valid[i] && (CNT_W'(rank[i]) < limit)) begin
          rank_next[i] = rank[i] + IDX_W'(1);
        end
      end
    end
  end

  // Result word
  always_comb begin
    rsp_next.found      = hit;
    rsp_next.read_value = (hit && !is_put) ? values[hit_idx] : '0;
    rsp_next.evicted    = do_evict;
  end

  // Control state update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      used  <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (req_vld) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
      if (do_insert) begin
        valid[wr_idx] <= 1'b1;
        used          <= used + CNT_W'(1);
      end
    end
  end

  // Key and value storage
  always_ff @(posedge clk) begin
    if (req_vld && do_write) begin
      keys[wr_idx]   <= req_q.key;
      values[wr_idx] <= req_q.value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== tb/sv/lru_key_value_cache_test.sv =====
// Self-checking testbench for the LRU key-value cache: directed table, then random traffic.
`timescale 1ns / 1ps

module lru_key_value_cache_test;
  import lru_kv_pkg::*;

  localparam int RESULT_LATENCY = 2;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int N_PHASES       = 9;
  localparam int PHASE_WORDS    = 172;
  localparam int POOL_SIZE      = 32;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One row of the directed table: a request word or a capacity write
  typedef struct packed {
    row_kind_e        kind;
    req_t             word;
    logic [CAP_W-1:0] cap;
    logic             typed;
    rsp_t             want;
  } row_t;

  localparam int N_ROWS = 22;

  row_t dir_rows [N_ROWS] = '{
    // empty cache: get misses
    '{ROW_REQ, '{REQ_GET, 32'sh00000000, 32'sh00000000}, 5'd0, 1'b1, '{1'b0, 32'sh0, 1'b0}},
    // extreme keys and values
    '{ROW_REQ, '{REQ_PUT, 32'sh80000000, 32'sh7FFFFFFF}, 5'd0, 1'b1, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_PUT, 32'sh7FFFFFFF, 32'sh80000000}, 5'd0, 1'b1, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_GET, 32'sh80000000, 32'sh00000000}, 5'd0, 1'b1,
      '{1'b1, 32'sh7FFFFFFF, 1'b0}},
    '{ROW_REQ, '{REQ_GET, 32'sh7FFFFFFF, 32'shFFFFFFFF}, 5'd0, 1'b1,
      '{1'b1, 32'sh80000000, 1'b0}},
    // put to a present key: found, nothing read, no eviction
    '{ROW_REQ, '{REQ_PUT, 32'sh80000000, 32'shFFFFFFFF}, 5'd0, 1'b1, '{1'b1, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_GET, 32'sh80000000, 32'sh00000000}, 5'd0, 1'b1,
      '{1'b1, 32'shFFFFFFFF, 1'b0}},
    '{ROW_REQ, '{REQ_PUT, 32'shFFFFFFFF, 32'sh00000000}, 5'd0, 1'b1, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_GET, 32'sh00000001, 32'sh00000000}, 5'd0, 1'b1, '{1'b0, 32'sh0, 1'b0}},
    // capacity dropped below the fill count: new keys evict the oldest entry
    '{ROW_CFG, '{REQ_GET, 32'sh0, 32'sh0}, 5'd1, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_PUT, 32'sh00000001, 32'sh12345678}, 5'd0, 1'b1, '{1'b0, 32'sh0, 1'b1}},
    '{ROW_REQ, '{REQ_GET, 32'sh7FFFFFFF, 32'sh00000000}, 5'd0, 1'b1, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_GET, 32'sh80000000, 32'sh00000000}, 5'd0, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_PUT, 32'sh7FFFFFFF, 32'sh55555555}, 5'd0, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    // capacity zero acts as one
    '{ROW_CFG, '{REQ_GET, 32'sh0, 32'sh0}, 5'd0, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_PUT, 32'shAAAAAAAA, 32'shAAAAAAAA}, 5'd0, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_GET, 32'shAAAAAAAA, 32'sh00000000}, 5'd0, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    // capacity above the entry count saturates
    '{ROW_CFG, '{REQ_GET, 32'sh0, 32'sh0}, 5'd31, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_PUT, 32'sh00000002, 32'sh00000002}, 5'd0, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_GET, 32'shFFFFFFFF, 32'sh00000000}, 5'd0, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_CFG, '{REQ_GET, 32'sh0, 32'sh0}, 5'd16, 1'b0, '{1'b0, 32'sh0, 1'b0}},
    '{ROW_REQ, '{REQ_PUT, 32'sh7FFFFFFF, 32'sh00000000}, 5'd0, 1'b0, '{1'b0, 32'sh0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic done;
  rsp_t rsp;

  lru_key_value_cache uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .rsp         (rsp)
  );

  always #2 clk = ~clk;

  // Cache contents as the testbench expects them
  logic signed [KEY_W-1:0] shadow_key  [MAX_ENTRIES];
  logic signed [VAL_W-1:0] shadow_val  [MAX_ENTRIES];
  bit                      shadow_vld  [MAX_ENTRIES];
  int unsigned             shadow_rank [MAX_ENTRIES];
  int unsigned             shadow_used = 0;
  logic [CAP_W-1:0]        shadow_cap  = 5'd16;

  rsp_t expected_rsp [$];
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   n_words     = 0;
  int   n_hits      = 0;
  int   n_evicts    = 0;
  int   n_cfg       = 0;

  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [CAP_W-1:0]        phase_cap [N_PHASES] = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0,
                                                   5'd5, 5'd17, 5'd8, 5'd3};

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_vld[i]  = 1'b0;
      shadow_rank[i] = 0;
    end
  end

  // Move entry idx to the front; valid entries newer than limit age by one
  function automatic void make_newest(input int idx, input int unsigned limit);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i != idx && shadow_vld[i] && shadow_rank[i] < limit) shadow_rank[i]++;
    end
    shadow_rank[idx] = 0;
  endfunction

  // Expected result of one request word; updates the shadow cache
  function automatic rsp_t predict_response(input req_t w);
    rsp_t        o;
    int          hit;
    int          slot;
    int unsigned worst;
    int unsigned eff_cap;
    bit          seen;
    o   = '0;
    hit = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit < 0 && shadow_vld[i] && shadow_key[i] == w.key) hit = i;
    end
    eff_cap = (shadow_cap == 0) ? 1 : ((shadow_cap > MAX_ENTRIES) ? MAX_ENTRIES : shadow_cap);
    if (hit >= 0) begin
      o.found = 1'b1;
      if (w.req_type == REQ_PUT) shadow_val[hit] = w.value;
      else o.read_value = shadow_val[hit];
      make_newest(hit, shadow_rank[hit]);
    end else if (w.req_type == REQ_PUT) begin
      slot = 0;
      if (shadow_used >= eff_cap && shadow_used > 0) begin
        // replace the oldest valid entry
        worst = 0;
        seen  = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (shadow_vld[i] && (!seen || shadow_rank[i] > worst)) begin
            worst = shadow_rank[i];
            slot  = i;
            seen  = 1'b1;
          end
        end
        o.evicted        = 1'b1;
        shadow_key[slot] = w.key;
        shadow_val[slot] = w.value;
        make_newest(slot, worst);
      end else begin
        // first free entry
        seen = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (!seen && !shadow_vld[i]) begin
            slot = i;
            seen = 1'b1;
          end
        end
        shadow_vld[slot] = 1'b1;
        shadow_key[slot] = w.key;
        shadow_val[slot] = w.value;
        shadow_used++;
        make_newest(slot, shadow_used);
      end
    end
    return o;
  endfunction

  // Send one request word after a random gap; queue its expected result
  task automatic issue_request(input req_t w, input logic typed, input rsp_t want,
                               input int idle_pct);
    rsp_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
    pred = predict_response(w);
    expected_rsp.push_back(typed ? want : pred);
    n_words++;
    if (pred.found && w.req_type == REQ_GET) n_hits++;
    if (pred.evicted) n_evicts++;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  // Capacity write, only with the cache idle
  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    shadow_cap = c;
    cfg_wr_en <= 1'b0;
    n_cfg++;
  endtask

  // Result checker: every strobed word against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        $error("result word with no request outstanding");
        fail_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, rsp.found);
          fail_count++;
        end
        if (rsp.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
          fail_count++;
        end
        if (rsp.evicted !== want.evicted) begin
          $error("evicted: expected %0b, got %0b", want.evicted, rsp.evicted);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    req_t w;
    int   idle_pct;
    int   pool_n;
    key_pool[0] = 32'sh80000000;
    key_pool[1] = 32'sh7FFFFFFF;
    key_pool[2] = 32'shFFFFFFFF;
    key_pool[3] = 32'sh00000000;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    phase_cap[N_PHASES-1] = CAP_W'($urandom_range(1, 16));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < N_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) write_capacity(dir_rows[r].cap);
      else issue_request(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want, 0);
    end

    // Random phases: gaps of 9%, then 76%, then none
    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(phase_cap[p]);
      idle_pct = (p < 3) ? 9 : ((p < 6) ? 76 : 0);
      pool_n   = $urandom_range(2, 24);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w.req_type = $urandom_range(1) ? REQ_PUT : REQ_GET;
        // mostly reused keys so gets hit and puts update or evict
        if ($urandom_range(99) < 85) w.key = key_pool[$urandom_range(pool_n - 1)];
        else w.key = $urandom;
        w.value = $urandom;
        issue_request(w, 1'b0, '0, idle_pct);
      end
    end

    drain_results();
    $display("Covered %0d requests and %0d capacity writes: %0d get hits, %0d evictions.",
             n_words, n_cfg, n_hits, n_evicts);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
